>>> src/mmll_pkg.sv
// Shared types, character codes and grammar table for the mail line lexer.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mmll_pkg;

  // Character codes the lexer reacts to
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Widths of the stream payloads
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Token class of a finished lexeme
  typedef enum logic [1:0] {
    CLS_HDR_NAME = 2'd0,
    CLS_LINE     = 2'd1,
    CLS_EMPTY    = 2'd2,
    CLS_EOI      = 2'd3
  } tok_cls_t;

  // Grammar state
  typedef enum logic [2:0] {
    GS_BEGIN     = 3'd0,
    GS_HDR_NAME  = 3'd1,
    GS_HDR_VALUE = 3'd2,
    GS_HDR_END   = 3'd3,
    GS_BODY      = 3'd4,
    GS_END       = 3'd5
  } gram_state_t;

  // Action attached to a grammar step
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_VALIDATE   = 3'd1,
    ACT_CHECK_STR  = 3'd2,
    ACT_PART_BEGIN = 3'd3,
    ACT_FINISH     = 3'd4
  } act_code_t;

  // Result kind on out_tuser
  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_LEXEME  = 1'b1;

  // Pair partner to drop after a line end
  typedef enum logic [1:0] {
    PS_NONE    = 2'd0,
    PS_DROP_CR = 2'd1,
    PS_DROP_LF = 2'd2
  } pair_skip_t;

  // Continuation line handling
  typedef enum logic [1:0] {
    CM_OFF     = 2'd0,
    CM_SKIP_WS = 2'd1,
    CM_COPY    = 2'd2
  } cont_mode_t;

  // Command handed from front to back
  typedef enum logic [1:0] {
    OP_CONTENT  = 2'd0,
    OP_LEXEME   = 2'd1,
    OP_EOI      = 2'd2,
    OP_EOI_LINE = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    tok_cls_t   cls;
    logic [7:0] data;
  } entry_t;

  // Back-end sequencer state
  typedef enum logic [1:0] {
    BK_RUN      = 2'd0,
    BK_EOI_PEND = 2'd1,
    BK_HALT     = 2'd2
  } back_state_t;

  typedef struct packed {
    logic        ok;
    gram_state_t nxt;
    act_code_t   act;
  } gram_step_t;

  // Grammar table: is the lexeme allowed, where does it lead, what action
  function automatic gram_step_t gram_step(gram_state_t s, tok_cls_t c);
    gram_step_t r;
    r.ok  = 1'b0;
    r.nxt = s;
    r.act = ACT_NONE;
    case (s)
      GS_BEGIN: begin
        if (c == CLS_HDR_NAME) begin
          r.ok = 1'b1; r.nxt = GS_HDR_NAME; r.act = ACT_VALIDATE;
        end
      end
      GS_HDR_NAME: begin
        if (c == CLS_LINE) begin
          r.ok = 1'b1; r.nxt = GS_HDR_VALUE; r.act = ACT_CHECK_STR;
        end
      end
      GS_HDR_VALUE: begin
        case (c)
          CLS_HDR_NAME: begin r.ok = 1'b1; r.nxt = GS_HDR_NAME;  r.act = ACT_VALIDATE;   end
          CLS_LINE:     begin r.ok = 1'b1; r.nxt = GS_HDR_VALUE; r.act = ACT_CHECK_STR;  end
          CLS_EMPTY:    begin r.ok = 1'b1; r.nxt = GS_HDR_END;   r.act = ACT_PART_BEGIN; end
          default:      r.ok = 1'b0;
        endcase
      end
      GS_HDR_END: begin
        case (c)
          CLS_HDR_NAME: begin r.ok = 1'b1; r.nxt = GS_BODY;    r.act = ACT_NONE;       end
          CLS_LINE:     begin r.ok = 1'b1; r.nxt = GS_BODY;    r.act = ACT_CHECK_STR;  end
          CLS_EMPTY:    begin r.ok = 1'b1; r.nxt = GS_HDR_END; r.act = ACT_PART_BEGIN; end
          CLS_EOI:      begin r.ok = 1'b1; r.nxt = GS_END;     r.act = ACT_FINISH;     end
          default:      r.ok = 1'b0;
        endcase
      end
      GS_BODY: begin
        case (c)
          CLS_HDR_NAME: begin r.ok = 1'b1; r.nxt = GS_BODY; r.act = ACT_NONE;      end
          CLS_LINE:     begin r.ok = 1'b1; r.nxt = GS_BODY; r.act = ACT_CHECK_STR; end
          CLS_EMPTY:    begin r.ok = 1'b1; r.nxt = GS_BODY; r.act = ACT_NONE;      end
          CLS_EOI:      begin r.ok = 1'b1; r.nxt = GS_END;  r.act = ACT_FINISH;    end
          default:      r.ok = 1'b0;
        endcase
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/mmll_front.sv
// Lexer front: takes bytes and end-of-input marks, tracks line state and
// emits one command per item that yields results. Depends on mmll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmll_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_eoi,
  output mmll_pkg::entry_t     push_data,
  output logic                 push
);

  logic                   ihv_r, ihv_nxt;
  logic                   body_r, body_nxt;
  logic                   has_bytes_r, has_bytes_nxt;
  logic                   done_r, done_nxt;
  mmll_pkg::pair_skip_t   pps_r, pps_nxt;
  mmll_pkg::cont_mode_t   cont_r, cont_nxt;

  logic is_eol, is_blank, is_ws_any, is_colon, skip_hit;

  // Classify the byte
  assign is_eol    = (in_byte == mmll_pkg::CH_LF) || (in_byte == mmll_pkg::CH_CR);
  assign is_blank  = (in_byte == mmll_pkg::CH_SPACE) || (in_byte == mmll_pkg::CH_TAB);
  assign is_ws_any = (in_byte == mmll_pkg::CH_SPACE) ||
                     ((in_byte >= mmll_pkg::CH_TAB) && (in_byte <= mmll_pkg::CH_CR));
  assign is_colon  = (in_byte == mmll_pkg::CH_COLON);
  assign skip_hit  = ((pps_r == mmll_pkg::PS_DROP_CR) && (in_byte == mmll_pkg::CH_CR)) ||
                     ((pps_r == mmll_pkg::PS_DROP_LF) && (in_byte == mmll_pkg::CH_LF));

  // Lexer step for one accepted item
  always_comb begin
    ihv_nxt       = ihv_r;
    body_nxt      = body_r;
    has_bytes_nxt = has_bytes_r;
    done_nxt      = done_r;
    pps_nxt       = pps_r;
    cont_nxt      = cont_r;
    push          = 1'b0;
    push_data.op   = mmll_pkg::OP_CONTENT;
    push_data.cls  = mmll_pkg::CLS_HDR_NAME;
    push_data.data = in_byte;

    if (in_fire && !done_r) begin
      if (in_eoi) begin
        pps_nxt  = mmll_pkg::PS_NONE;
        done_nxt = 1'b1;
        push     = 1'b1;
        push_data.op  = ((cont_r != mmll_pkg::CM_OFF) || has_bytes_r) ?
                        mmll_pkg::OP_EOI_LINE : mmll_pkg::OP_EOI;
        push_data.cls = mmll_pkg::CLS_EOI;
      end else begin
        pps_nxt = mmll_pkg::PS_NONE;
        if (!skip_hit) begin
          if (cont_r == mmll_pkg::CM_SKIP_WS) begin
            // drop leading white space of a continuation line
            if (!is_ws_any) begin
              cont_nxt = mmll_pkg::CM_COPY;
              push     = 1'b1;
            end
          end else if (is_eol) begin
            // line end: remember the pair partner, pick the class
            pps_nxt = (in_byte == mmll_pkg::CH_LF) ? mmll_pkg::PS_DROP_CR
                                                    : mmll_pkg::PS_DROP_LF;
            push         = 1'b1;
            push_data.op = mmll_pkg::OP_LEXEME;
            if (cont_r == mmll_pkg::CM_COPY) begin
              cont_nxt      = mmll_pkg::CM_OFF;
              push_data.cls = mmll_pkg::CLS_LINE;
            end else if (!has_bytes_r && !ihv_r) begin
              push_data.cls = mmll_pkg::CLS_EMPTY;
              body_nxt      = 1'b1;
              ihv_nxt       = 1'b0;
            end else begin
              push_data.cls = mmll_pkg::CLS_LINE;
              ihv_nxt       = 1'b0;
            end
            has_bytes_nxt = 1'b0;
          end else if (cont_r == mmll_pkg::CM_COPY) begin
            push = 1'b1;
          end else if (is_colon) begin
            if (ihv_r || body_r) begin
              has_bytes_nxt = 1'b1;
              push          = 1'b1;
            end else begin
              ihv_nxt       = 1'b1;
              has_bytes_nxt = 1'b0;
              push          = 1'b1;
              push_data.op  = mmll_pkg::OP_LEXEME;
              push_data.cls = mmll_pkg::CLS_HDR_NAME;
            end
          end else if (is_blank && !has_bytes_r && ihv_r) begin
            // drop blanks after the header colon
            push = 1'b0;
          end else if (is_blank && !has_bytes_r) begin
            cont_nxt = mmll_pkg::CM_SKIP_WS;
          end else begin
            has_bytes_nxt = 1'b1;
            push          = 1'b1;
          end
        end
      end
    end
  end

  // Hold lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ihv_r       <= 1'b0;
      body_r      <= 1'b0;
      has_bytes_r <= 1'b0;
      done_r      <= 1'b0;
      pps_r       <= mmll_pkg::PS_NONE;
      cont_r      <= mmll_pkg::CM_OFF;
    end else begin
      ihv_r       <= ihv_nxt;
      body_r      <= body_nxt;
      has_bytes_r <= has_bytes_nxt;
      done_r      <= done_nxt;
      pps_r       <= pps_nxt;
      cont_r      <= cont_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/mmll_fifo.sv
// Short command queue between lexer front and grammar back.
// Depends on mmll_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module mmll_fifo #(
  parameter int DEPTH = mmll_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  mmll_pkg::entry_t      wr_data,
  output logic                  full,
  input  wire logic             pop,
  output mmll_pkg::entry_t      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mmll_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

>>> src/mmll_back.sv
// Grammar back end: pops commands, steps the grammar table and drives
// the result register. Depends on mmll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmll_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  mmll_pkg::entry_t       q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic                   out_last,
  output logic [7:0]             out_byte,
  output mmll_pkg::tok_cls_t     out_cls,
  output mmll_pkg::gram_state_t  out_gs,
  output mmll_pkg::act_code_t    out_act,
  output logic                   out_wrong
);

  mmll_pkg::back_state_t  state_r, state_nxt;
  mmll_pkg::gram_state_t  gs_r, gs_nxt;
  mmll_pkg::gram_step_t   step;
  mmll_pkg::tok_cls_t     step_cls;

  logic                   valid_r, valid_nxt;
  logic                   load;
  logic                   kind_r, kind_nxt;
  logic                   last_r, last_nxt;
  logic [7:0]             byte_r, byte_nxt;
  mmll_pkg::tok_cls_t     cls_r, cls_nxt;
  mmll_pkg::gram_state_t  ogs_r, ogs_nxt;
  mmll_pkg::act_code_t    act_r, act_nxt;
  logic                   wrong_r, wrong_nxt;
  logic                   out_free;

  assign out_free = !valid_r || out_ready;

  // Pick the class that steps the grammar this cycle
  always_comb begin
    if (state_r == mmll_pkg::BK_EOI_PEND) begin
      step_cls = mmll_pkg::CLS_EOI;
    end else begin
      case (q_data.op)
        mmll_pkg::OP_EOI:      step_cls = mmll_pkg::CLS_EOI;
        mmll_pkg::OP_EOI_LINE: step_cls = mmll_pkg::CLS_LINE;
        default:               step_cls = q_data.cls;
      endcase
    end
  end

  assign step = mmll_pkg::gram_step(gs_r, step_cls);

  // Next sequencer state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmll_pkg::BK_RUN: begin
        if (!q_empty && out_free) begin
          case (q_data.op)
            mmll_pkg::OP_LEXEME:   state_nxt = step.ok ? mmll_pkg::BK_RUN
                                                       : mmll_pkg::BK_HALT;
            mmll_pkg::OP_EOI:      state_nxt = mmll_pkg::BK_HALT;
            mmll_pkg::OP_EOI_LINE: state_nxt = step.ok ? mmll_pkg::BK_EOI_PEND
                                                       : mmll_pkg::BK_HALT;
            default:               state_nxt = mmll_pkg::BK_RUN;
          endcase
        end
      end
      mmll_pkg::BK_EOI_PEND: begin
        if (out_free) begin
          state_nxt = mmll_pkg::BK_HALT;
        end
      end
      mmll_pkg::BK_HALT: state_nxt = mmll_pkg::BK_HALT;
      default:           state_nxt = mmll_pkg::BK_HALT;
    endcase
  end

  // Sequencer outputs: pop, load the result register, step the grammar
  always_comb begin
    q_pop     = 1'b0;
    load      = 1'b0;
    gs_nxt    = gs_r;
    kind_nxt  = mmll_pkg::KIND_LEXEME;
    last_nxt  = 1'b1;
    byte_nxt  = '0;
    cls_nxt   = step_cls;
    ogs_nxt   = step.ok ? step.nxt : gs_r;
    act_nxt   = step.ok ? step.act : mmll_pkg::ACT_NONE;
    wrong_nxt = !step.ok;
    case (state_r)
      mmll_pkg::BK_RUN: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          case (q_data.op)
            mmll_pkg::OP_CONTENT: begin
              kind_nxt  = mmll_pkg::KIND_CONTENT;
              byte_nxt  = q_data.data;
              cls_nxt   = mmll_pkg::CLS_HDR_NAME;
              ogs_nxt   = gs_r;
              act_nxt   = mmll_pkg::ACT_NONE;
              wrong_nxt = 1'b0;
            end
            mmll_pkg::OP_EOI_LINE: begin
              last_nxt = !step.ok;
              gs_nxt   = step.ok ? step.nxt : gs_r;
            end
            default: begin
              gs_nxt = step.ok ? step.nxt : gs_r;
            end
          endcase
        end
      end
      mmll_pkg::BK_EOI_PEND: begin
        if (out_free) begin
          load   = 1'b1;
          gs_nxt = step.ok ? step.nxt : gs_r;
        end
      end
      mmll_pkg::BK_HALT: begin
        // drain and drop everything after the end
        q_pop = !q_empty;
      end
      default: q_pop = 1'b0;
    endcase
  end

  // Output valid: set on load, clear when taken
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmll_pkg::BK_RUN;
      gs_r    <= mmll_pkg::GS_BEGIN;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gs_r    <= gs_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      last_r  <= last_nxt;
      byte_r  <= byte_nxt;
      cls_r   <= cls_nxt;
      ogs_r   <= ogs_nxt;
      act_r   <= act_nxt;
      wrong_r <= wrong_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;
  assign out_byte  = byte_r;
  assign out_cls   = cls_r;
  assign out_gs    = ogs_r;
  assign out_act   = act_r;
  assign out_wrong = wrong_r;

`ifndef NO_ASSERTIONS
  a_wrong_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && wrong_r) |-> (last_r && (act_r == mmll_pkg::ACT_NONE) &&
                              (state_r == mmll_pkg::BK_HALT)))
    else $error("wrong lexeme without halt or with action");
  a_content_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == mmll_pkg::KIND_CONTENT)) |-> (last_r && !wrong_r))
    else $error("content result not last");
  a_eoi_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == mmll_pkg::KIND_LEXEME) && (cls_r == mmll_pkg::CLS_EOI))
      |-> (state_r == mmll_pkg::BK_HALT))
    else $error("end of input result while still running");
`endif

endmodule

`default_nettype wire

>>> src/mail_message_line_lexer.sv
// Top level of the mail line lexer: front, command queue and grammar back.
// Depends on mmll_pkg, mmll_front, mmll_fifo and mmll_back.
//
//   Channel  Dir  tdata                              tuser           tlast
//   in_      in   data_byte[7:0]                     end_of_input    -
//   out_     out  content_byte, token_class,         result_kind     last_result
//                 grammar_state, action_code, wrong
//
// One input item per cycle while in_tready is high. End of input with an open
// line yields two results if the grammar accepts the line, and the back end
// holds for the second. Throughput is set by the single result register. Reset
// is synchronous and clears all control state at once; no clearing pass.
// Either side may stall: the queue absorbs up to QUEUE_DEPTH commands before
// in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module mail_message_line_lexer #(
  parameter int QUEUE_DEPTH = mmll_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mmll_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  wire logic                             in_tuser,   // [0] end_of_input
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] content_byte, [9:8] token_class, [12:10] grammar_state,
  // [15:13] action_code, [16] wrong_lexeme, [23:17] zero
  output logic [mmll_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tuser,  // [0] result_kind
  output logic                                  out_tlast   // last_result
);

  mmll_pkg::entry_t       push_data, q_data;
  logic                   push, q_full, q_empty, q_pop, in_fire;
  logic [7:0]             res_byte;
  mmll_pkg::tok_cls_t     res_cls;
  mmll_pkg::gram_state_t  res_gs;
  mmll_pkg::act_code_t    res_act;
  logic                   res_wrong;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  mmll_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata[7:0]),
    .in_eoi    (in_tuser),
    .push_data (push_data),
    .push      (push)
  );

  mmll_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  mmll_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_last  (out_tlast),
    .out_byte  (res_byte),
    .out_cls   (res_cls),
    .out_gs    (res_gs),
    .out_act   (res_act),
    .out_wrong (res_wrong)
  );

  // Pack result fields, lowest first
  assign out_tdata = {7'd0, res_wrong, res_act, res_gs, res_cls, res_byte};

endmodule

`default_nettype wire
